>>> hw/rtl/mssw_pkg.sv
// ----------------------------------------------------------------------------
// MIDI square-wave synth package
// Shared payload types, protocol constants and the note period table builder.
// ----------------------------------------------------------------------------
package mssw_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] META_END    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;

  localparam logic [23:0] TEMPO_RESET = 24'd500000;
  localparam logic [7:0]  GAIN_RESET  = 8'd10;

  localparam int PERIOD_W  = 13;
  localparam int SUM_W     = 12;
  localparam int TAB_DEPTH = 128;

  typedef struct packed {
    logic       op;
    logic [7:0] midi_byte;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               stream_done;
    logic               format_error;
    logic [23:0]        current_tempo;
  } out_t;

  typedef logic [PERIOD_W-1:0] period_tab_t [TAB_DEPTH];

  // Equal-tempered periods in samples, note 69 at 440 Hz, clamped to 1..8191.
  function automatic period_tab_t build_periods(input int unsigned sr);
    logic [63:0] fq [TAB_DEPTH];
    logic [63:0] f;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    period_tab_t tab;
    fq[69] = 64'd440 << 32;
    f = fq[69];
    for (int i = 70; i < TAB_DEPTH; i++) begin
      f = (f * 64'd105946 + 64'd50000) / 64'd100000;
      fq[i] = f;
    end
    f = fq[69];
    for (int i = 68; i >= 0; i--) begin
      f = (f * 64'd100000 + 64'd52973) / 64'd105946;
      fq[i] = f;
    end
    for (int i = 0; i < TAB_DEPTH; i++) begin
      num = 64'(sr) << 32;
      q = '0;
      r = '0;
      if (fq[i] == 64'd0) begin
        q = 64'd8191;
      end else begin
        for (int b = 63; b >= 0; b--) begin
          r = {r[62:0], num[b]};
          if (r >= fq[i]) begin
            r = r - fq[i];
            q[b] = 1'b1;
          end
        end
      end
      if (q < 64'd1) q = 64'd1;
      if (q > 64'd8191) q = 64'd8191;
      tab[i] = q[PERIOD_W-1:0];
    end
    return tab;
  endfunction

endpackage

>>> hw/rtl/mssw_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mssw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/midi_event_square_wave_synth_unit.sv
// ----------------------------------------------------------------------------
// MIDI event square-wave synth
// Running-status MIDI parser feeding a per-note velocity table, and a
// square-wave mixer that produces one sample per tick request.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2**(clog2(CHANNEL_COUNT) + clog2(NOTE_COUNT))
// velocity entries (2048 at the defaults), clearing the note memory too, and
// takes no request meanwhile. A byte that completes a note on or off within the
// table passes through a read state and a write state for the read-modify-write
// of the velocity and note-sum memories. A tick walks the note memory one entry
// per cycle through its single read port. A finished sample waits in the output
// register while the next request is taken.
module midi_event_square_wave_synth_unit
  import mssw_pkg::*;
#(
  parameter int NOTE_COUNT    = 128,
  parameter int CHANNEL_COUNT = 16,
  parameter int SAMPLE_RATE   = 44100
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int NW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int VA = CW + NW;
  localparam int IW = $clog2(NOTE_COUNT + 1);
  localparam int SPW = SUM_W + PERIOD_W;
  localparam period_tab_t PERIODS = build_periods(SAMPLE_RATE);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_WR    = 6'b001000,
    S_TICK  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef enum logic [11:0] {
    P_IDLE      = 12'b000000000001,
    P_OFF_KEY   = 12'b000000000010,
    P_OFF_VEL   = 12'b000000000100,
    P_ON_KEY    = 12'b000000001000,
    P_ON_VEL    = 12'b000000010000,
    P_SKIP1     = 12'b000000100000,
    P_SKIP2     = 12'b000001000000,
    P_SYSEX     = 12'b000010000000,
    P_META_KIND = 12'b000100000000,
    P_META_LEN  = 12'b001000000000,
    P_TEMPO     = 12'b010000000000,
    P_META_SKIP = 12'b100000000000
  } parse_t;

  function automatic parse_t begin_event(input logic [7:0] s);
    parse_t p;
    case (s[7:4])
      4'h8: p = P_OFF_KEY;
      4'h9: p = P_ON_KEY;
      4'hA, 4'hC, 4'hD: p = P_SKIP1;
      4'hB, 4'hE: p = P_SKIP2;
      4'hF: p = (s == SYSEX_START) ? P_SYSEX : P_META_KIND;
      default: p = P_IDLE;
    endcase
    return p;
  endfunction

  state_t state_r, state_nxt;
  parse_t ph_r, ph_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [7:0]  fd_r, fd_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [23:0] tempo_r, tempo_nxt;
  logic        ended_r, ended_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  gain_r;
  logic [VA:0] clr_r;
  logic [NW-1:0] nkey_r;
  logic [CW-1:0] nch_r;
  logic [7:0]    nvel_r;
  logic [IW-1:0] idx_r;
  logic          pv_r;
  logic [NW-1:0] pidx_r;
  logic [15:0]   tot_r;
  logic          out_valid_r;
  out_t          out_r;

  logic       in_go, byte_go, tick_go;
  logic       feed;
  parse_t     eff;
  logic [7:0] b;
  logic       note_req;
  logic [6:0] note_key;
  logic [7:0] note_vel;
  logic       note_ok;
  logic [7:0] skip_dec;

  // memory ports
  logic          vel_we;
  logic [VA-1:0] vel_waddr, vel_raddr;
  logic [7:0]    vel_wdata, vel_rdata;
  logic          sp_we;
  logic [NW-1:0] sp_waddr, sp_raddr;
  logic [SPW-1:0] sp_wdata, sp_rdata;
  logic [SUM_W-1:0]    rd_sum, new_sum;
  logic [PERIOD_W-1:0] rd_ph, ph_inc, new_ph, per;
  logic [15:0]   tot_add;
  logic [23:0]   prod;

  assign in_stall = (state_r != S_IDLE);
  assign in_go    = in_valid && !in_stall;
  assign byte_go  = in_go && (in_data.op == OP_BYTE);
  assign tick_go  = in_go && (in_data.op == OP_TICK);
  assign b        = in_data.midi_byte;
  assign skip_dec = skip_r - 8'd1;

  // Parser
  always_comb begin
    ph_nxt    = ph_r;
    rs_nxt    = rs_r;
    fd_nxt    = fd_r;
    kind_nxt  = kind_r;
    skip_nxt  = skip_r;
    tempo_nxt = tempo_r;
    ended_nxt = ended_r;
    err_nxt   = err_r;
    feed      = 1'b0;
    eff       = ph_r;
    note_req  = 1'b0;
    note_key  = fd_r[6:0];
    note_vel  = 8'd0;
    if (byte_go && !ended_r) begin
      if (ph_r != P_IDLE) begin
        feed = 1'b1;
      end else if (b[7]) begin
        rs_nxt = (b >= SYSEX_START) ? 8'd0 : b;
        ph_nxt = begin_event(b);
      end else if (rs_r[7]) begin
        eff  = begin_event(rs_r);
        feed = 1'b1;
      end else begin
        err_nxt = 1'b1;
      end
    end
    if (feed) begin
      case (eff)
        P_OFF_KEY: begin
          fd_nxt = b;
          ph_nxt = P_OFF_VEL;
        end
        P_OFF_VEL: begin
          note_req = 1'b1;
          ph_nxt   = P_IDLE;
        end
        P_ON_KEY: begin
          fd_nxt = b;
          ph_nxt = P_ON_VEL;
        end
        P_ON_VEL: begin
          note_req = 1'b1;
          note_vel = b;
          ph_nxt   = P_IDLE;
        end
        P_SKIP2: ph_nxt = P_SKIP1;
        P_SKIP1: ph_nxt = P_IDLE;
        P_SYSEX: ph_nxt = (b == SYSEX_END) ? P_IDLE : P_SYSEX;
        P_META_KIND: begin
          kind_nxt = b;
          ph_nxt   = P_META_LEN;
        end
        P_META_LEN: begin
          skip_nxt = b;
          if (kind_r == META_END) begin
            ended_nxt = 1'b1;
            ph_nxt    = P_IDLE;
          end else if (b == 8'd0) begin
            ph_nxt = P_IDLE;
          end else if (kind_r == META_TEMPO) begin
            tempo_nxt = '0;
            ph_nxt    = P_TEMPO;
          end else begin
            ph_nxt = P_META_SKIP;
          end
        end
        P_TEMPO: begin
          tempo_nxt = {tempo_r[15:0], b};
          skip_nxt  = skip_dec;
          ph_nxt    = (skip_dec == 8'd0) ? P_IDLE : P_TEMPO;
        end
        P_META_SKIP: begin
          skip_nxt = skip_dec;
          ph_nxt   = (skip_dec == 8'd0) ? P_IDLE : P_META_SKIP;
        end
        default: ph_nxt = P_IDLE;
      endcase
    end
  end

  // drop notes outside the table
  assign note_ok = ({1'b0, note_key} < 8'(NOTE_COUNT)) &&
                   ({1'b0, rs_r[3:0]} < 5'(CHANNEL_COUNT));

  // Tick datapath
  assign rd_sum  = sp_rdata[SPW-1:PERIOD_W];
  assign rd_ph   = sp_rdata[PERIOD_W-1:0];
  assign per     = PERIODS[pidx_r];
  assign ph_inc  = rd_ph + PERIOD_W'(1);
  assign new_ph  = (ph_inc >= per) ? '0 : ph_inc;
  assign tot_add = (rd_ph >= (per >> 1)) ? (tot_r + 16'(rd_sum)) : tot_r;
  assign new_sum = rd_sum - SUM_W'(vel_rdata) + SUM_W'(nvel_r);
  assign prod    = tot_r * gain_r;

  // Memory port muxing
  always_comb begin
    vel_we    = 1'b0;
    vel_waddr = {nch_r, nkey_r};
    vel_wdata = nvel_r;
    vel_raddr = {nch_r, nkey_r};
    sp_we     = 1'b0;
    sp_waddr  = nkey_r;
    sp_wdata  = {new_sum, rd_ph};
    sp_raddr  = (state_r == S_TICK) ? idx_r[NW-1:0] : nkey_r;
    case (state_r)
      S_CLEAR: begin
        vel_we    = 1'b1;
        vel_waddr = clr_r[VA-1:0];
        vel_wdata = '0;
        sp_we     = 1'b1;
        sp_waddr  = clr_r[NW-1:0];
        sp_wdata  = '0;
      end
      S_WR: begin
        vel_we = 1'b1;
        sp_we  = 1'b1;
      end
      S_TICK: begin
        sp_we    = pv_r;
        sp_waddr = pidx_r;
        sp_wdata = {rd_sum, new_ph};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == (VA+1)'((1 << VA) - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (tick_go) begin
          state_nxt = S_TICK;
        end else if (note_req && note_ok) begin
          state_nxt = S_RD;
        end
      end
      S_RD:   state_nxt = S_WR;
      S_WR:   state_nxt = S_IDLE;
      S_TICK: if (pv_r && (pidx_r == NW'(NOTE_COUNT - 1))) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ph_r        <= P_IDLE;
      rs_r        <= '0;
      fd_r        <= '0;
      kind_r      <= '0;
      skip_r      <= '0;
      tempo_r     <= TEMPO_RESET;
      ended_r     <= 1'b0;
      err_r       <= 1'b0;
      gain_r      <= GAIN_RESET;
      clr_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ph_r     <= ph_nxt;
      rs_r     <= rs_nxt;
      fd_r     <= fd_nxt;
      kind_r   <= kind_nxt;
      skip_r   <= skip_nxt;
      tempo_r  <= tempo_nxt;
      ended_r  <= ended_nxt;
      err_r    <= err_nxt;
      if (cfg_we) gain_r <= cfg_wdata;
      if (state_r == S_CLEAR) clr_r <= clr_r + (VA+1)'(1);
      pv_r <= (state_r == S_TICK) && (idx_r < IW'(NOTE_COUNT));
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && note_req) begin
      nkey_r <= note_key[NW-1:0];
      nch_r  <= rs_r[CW-1:0];
      nvel_r <= note_vel;
    end
    if (tick_go) begin
      idx_r <= '0;
      tot_r <= '0;
    end else if (state_r == S_TICK) begin
      if (idx_r < IW'(NOTE_COUNT)) idx_r <= idx_r + IW'(1);
      pidx_r <= idx_r[NW-1:0];
      if (pv_r) tot_r <= tot_add;
    end
    if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_r.sample        <= ended_r ? 16'sd0 : signed'(prod[15:0]);
      out_r.stream_done   <= ended_r;
      out_r.format_error  <= err_r;
      out_r.current_tempo <= tempo_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  mssw_ram #(.WIDTH(8), .DEPTH(1 << VA)) u_vel_ram (
    .clk   (clk),
    .we    (vel_we),
    .waddr (vel_waddr),
    .wdata (vel_wdata),
    .raddr (vel_raddr),
    .rdata (vel_rdata)
  );

  mssw_ram #(.WIDTH(SPW), .DEPTH(1 << NW)) u_note_ram (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

endmodule

>>> hw/rtl/mssw_chk.sv
// ----------------------------------------------------------------------------
// MIDI square-wave synth port checker
// Watches the top-level ports for handshake, reset, silence and sticky-flag behavior.
// ----------------------------------------------------------------------------
module mssw_chk
  import mssw_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic seen_done_r;
  logic seen_err_r;

  // remember flags from delivered samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_done_r <= 1'b0;
      seen_err_r  <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (out_data.stream_done) seen_done_r <= 1'b1;
      if (out_data.format_error) seen_err_r <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled request changed");

  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_done |-> out_data.sample == 16'sd0)
    else $error("sample not silent after end of track");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_done_r |-> out_data.stream_done)
    else $error("stream_done dropped");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_err_r |-> out_data.format_error)
    else $error("format_error dropped");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("request out of reset");

endmodule

bind midi_event_square_wave_synth_unit mssw_chk u_mssw_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
